FILE: sv/spq_pkg.sv
// Shared constants and codes for the strict priority queue core.
package spq_pkg;

    localparam int DEF_POOL_ENTRIES = 64;
    localparam int DEF_NUM_CLASSES  = 4;

    localparam int TAG_W   = 32;
    localparam int OP_W    = 2;
    localparam int CLS_W   = 3;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 7;
    localparam int CNT_W   = 3;
    localparam int SERVE_W = 16;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_CALL   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_CLASS = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

endpackage

FILE: sv/spq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/strict_priority_four_class_queue_core.sv
// Top level of the strict priority four class queue core.
//
//  channel  | handshake           | beat contents
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_ready | opcode, entry_tag, urgency_class
//  output   | out_valid/out_ready | status, served/removed, lengths, total
//
// Add passes through the states ADD_RD and ADD_WR and call through CALL_RD
// and CALL_WR, as the link and tag memories have registered reads. Remove
// walks every class list in turn, reading and checking each visited slot.
// After reset a clearing pass over all POOL_ENTRIES slots builds the free
// chain in the link memory; no beat is taken until it ends. A result beat
// waits in the output register; the next beat is taken only once it is gone.
module strict_priority_four_class_queue_core
    import spq_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int NUM_CLASSES  = DEF_NUM_CLASSES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [TAG_W-1:0]   entry_tag,
    input  logic [CLS_W-1:0]   urgency_class,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  status,
    output logic [TAG_W-1:0]   served_tag,
    output logic [CLS_W-1:0]   served_class,
    output logic [CNT_W-1:0]   removed_count,
    output logic [LEN_W-1:0]   class1_length,
    output logic [LEN_W-1:0]   class2_length,
    output logic [LEN_W-1:0]   class3_length,
    output logic [LEN_W-1:0]   class4_length,
    output logic [SERVE_W-1:0] total_served
);

    localparam int SW = $clog2(POOL_ENTRIES);
    localparam int CW = $clog2(NUM_CLASSES);
    localparam int UW = SW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_ENTRIES - 1);
    localparam logic [CW-1:0] LAST_CLS  = CW'(NUM_CLASSES - 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ADD_RD, S_ADD_WR, S_CALL_RD, S_CALL_WR,
        S_RM_CLASS, S_RM_RD, S_RM_CHK, S_RM_NEXT, S_OUT
    } state_t;

    state_t state_reg;

    // Memories
    logic          nx_we;
    logic [SW-1:0] nx_wa, nx_wd, nx_ra, nx_rd;
    logic          tg_we;
    logic [SW-1:0] tg_wa, tg_ra;
    logic [TAG_W-1:0] tg_wd, tg_rd;

    spq_ram #(.WIDTH(SW), .DEPTH(POOL_ENTRIES)) u_next_ram (
        .clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
        .rd_addr(nx_ra), .rd_data(nx_rd)
    );

    spq_ram #(.WIDTH(TAG_W), .DEPTH(POOL_ENTRIES)) u_tag_ram (
        .clk(clk), .wr_en(tg_we), .wr_addr(tg_wa), .wr_data(tg_wd),
        .rd_addr(tg_ra), .rd_data(tg_rd)
    );

    // Control registers
    logic [SW-1:0]    head_reg [NUM_CLASSES];
    logic [SW-1:0]    tail_reg [NUM_CLASSES];
    logic [UW-1:0]    len_reg  [NUM_CLASSES];
    logic [SW-1:0]    free_head_reg;
    logic [UW-1:0]    used_reg;
    logic [SERVE_W-1:0] served_reg;
    logic [SW-1:0]    init_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [CW-1:0]    cls_reg;
    logic [SW-1:0]    slot_reg, cur_reg, prev_reg;
    logic [UW-1:0]    k_reg;
    logic [CW:0]      rm_reg;
    logic [STAT_W-1:0] status_reg;
    logic [TAG_W-1:0] stag_reg;
    logic [CLS_W-1:0] scls_reg;

    logic pool_full;
    assign pool_full = (used_reg >= UW'(POOL_ENTRIES));

    // Memory port steering
    always_comb
    begin
        nx_we = 1'b0;
        nx_wa = '0;
        nx_wd = '0;
        nx_ra = cur_reg;
        tg_we = 1'b0;
        tg_wa = slot_reg;
        tg_wd = tag_reg;
        tg_ra = cur_reg;
        case (state_reg)
            S_INIT:
            begin
                nx_we = 1'b1;
                nx_wa = init_reg;
                nx_wd = (init_reg == LAST_SLOT) ? '0 : init_reg + 1'b1;
            end
            S_IDLE:
            begin
                nx_ra = free_head_reg;
            end
            S_ADD_WR:
            begin
                // Link the new slot behind the tail, or write its own null link
                tg_we = 1'b1;
                nx_we = 1'b1;
                if (len_reg[cls_reg] != '0)
                begin
                    nx_wa = tail_reg[cls_reg];
                    nx_wd = slot_reg;
                end
                else
                begin
                    nx_wa = slot_reg;
                    nx_wd = '0;
                end
            end
            S_CALL_WR:
            begin
                nx_we = 1'b1;
                nx_wa = slot_reg;
                nx_wd = free_head_reg;
            end
            S_RM_CHK:
            begin
                if (tg_rd == tag_reg)
                begin
                    nx_we = 1'b1;
                    nx_wa = (k_reg != '0) ? prev_reg : cur_reg;
                    nx_wd = (k_reg != '0) ? nx_rd : free_head_reg;
                end
            end
            S_RM_NEXT:
            begin
                nx_we = 1'b1;
                nx_wa = cur_reg;
                nx_wd = free_head_reg;
            end
            default:
            begin
            end
        endcase
    end

    logic [CLS_W-1:0] ucls_m1;
    assign ucls_m1 = urgency_class - 1'b1;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            free_head_reg <= '0;
            used_reg      <= '0;
            served_reg    <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                len_reg[i]  <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == LAST_SLOT)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        tag_reg    <= entry_tag;
                        stag_reg   <= '0;
                        scls_reg   <= '0;
                        rm_reg     <= '0;
                        status_reg <= ST_OK;
                        cls_reg    <= '0;
                        k_reg      <= '0;
                        case (opcode)
                            OP_ADD:
                            begin
                                cls_reg <= CW'(ucls_m1);
                                if (urgency_class == '0 ||
                                    int'(urgency_class) > NUM_CLASSES)
                                begin
                                    status_reg <= ST_BAD_CLASS;
                                    state_reg  <= S_OUT;
                                end
                                else if (pool_full)
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    slot_reg  <= free_head_reg;
                                    state_reg <= S_ADD_RD;
                                end
                            end
                            OP_CALL:
                            begin
                                state_reg  <= S_OUT;
                                status_reg <= ST_EMPTY;
                                // Pick the non-empty class with the lowest number
                                for (int c = NUM_CLASSES - 1; c >= 0; c--)
                                begin
                                    if (len_reg[c] != '0)
                                    begin
                                        cls_reg    <= CW'(c);
                                        cur_reg    <= head_reg[c];
                                        slot_reg   <= head_reg[c];
                                        status_reg <= ST_OK;
                                        state_reg  <= S_CALL_RD;
                                    end
                                end
                            end
                            OP_REMOVE:
                            begin
                                state_reg <= S_RM_CLASS;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_ADD_RD:
                begin
                    // Free-list successor is on nx_rd
                    free_head_reg <= nx_rd;
                    state_reg     <= S_ADD_WR;
                end
                S_ADD_WR:
                begin
                    if (len_reg[cls_reg] == '0)
                    begin
                        head_reg[cls_reg] <= slot_reg;
                    end
                    tail_reg[cls_reg] <= slot_reg;
                    len_reg[cls_reg]  <= len_reg[cls_reg] + 1'b1;
                    used_reg          <= used_reg + 1'b1;
                    state_reg         <= S_OUT;
                end
                S_CALL_RD:
                begin
                    state_reg <= S_CALL_WR;
                end
                S_CALL_WR:
                begin
                    stag_reg          <= tg_rd;
                    scls_reg          <= CLS_W'(cls_reg) + 1'b1;
                    head_reg[cls_reg] <= nx_rd;
                    len_reg[cls_reg]  <= len_reg[cls_reg] - 1'b1;
                    free_head_reg     <= slot_reg;
                    if (used_reg != '0)
                    begin
                        used_reg <= used_reg - 1'b1;
                    end
                    served_reg <= served_reg + 1'b1;
                    state_reg  <= S_OUT;
                end
                S_RM_CLASS:
                begin
                    // Start a walk of class cls_reg
                    cur_reg  <= head_reg[cls_reg];
                    prev_reg <= '0;
                    k_reg    <= '0;
                    if (len_reg[cls_reg] == '0)
                    begin
                        if (cls_reg == LAST_CLS)
                        begin
                            if (rm_reg == '0)
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            cls_reg <= cls_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RM_RD;
                    end
                end
                S_RM_RD:
                begin
                    state_reg <= S_RM_CHK;
                end
                S_RM_CHK:
                begin
                    if (tg_rd == tag_reg)
                    begin
                        if (k_reg == '0)
                        begin
                            head_reg[cls_reg] <= nx_rd;
                        end
                        if (k_reg + 1'b1 == len_reg[cls_reg])
                        begin
                            tail_reg[cls_reg] <= prev_reg;
                        end
                        len_reg[cls_reg] <= len_reg[cls_reg] - 1'b1;
                        rm_reg <= rm_reg + 1'b1;
                        if (k_reg != '0)
                        begin
                            // Free cur next cycle; prev link written now
                            state_reg <= S_RM_NEXT;
                        end
                        else
                        begin
                            free_head_reg <= cur_reg;
                            if (used_reg != '0)
                            begin
                                used_reg <= used_reg - 1'b1;
                            end
                            state_reg <= S_RM_CLASS;
                            if (cls_reg == LAST_CLS)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                cls_reg <= cls_reg + 1'b1;
                            end
                        end
                    end
                    else if (k_reg + 1'b1 == len_reg[cls_reg])
                    begin
                        if (cls_reg == LAST_CLS)
                        begin
                            if (rm_reg == '0)
                            begin
                                status_reg <= ST_NOT_FOUND;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            cls_reg   <= cls_reg + 1'b1;
                            state_reg <= S_RM_CLASS;
                        end
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= nx_rd;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RM_RD;
                    end
                end
                S_RM_NEXT:
                begin
                    free_head_reg <= cur_reg;
                    if (used_reg != '0)
                    begin
                        used_reg <= used_reg - 1'b1;
                    end
                    if (cls_reg == LAST_CLS)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        cls_reg   <= cls_reg + 1'b1;
                        state_reg <= S_RM_CLASS;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Handshake and result fields
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = status_reg;
    assign served_tag    = stag_reg;
    assign served_class  = scls_reg;
    assign removed_count = CNT_W'(rm_reg);
    assign class1_length = LEN_W'(len_reg[0]);
    assign class2_length = LEN_W'(len_reg[1]);
    assign class3_length = (NUM_CLASSES > 2) ? LEN_W'(len_reg[CW'(2 % NUM_CLASSES)]) : '0;
    assign class4_length = (NUM_CLASSES > 3) ? LEN_W'(len_reg[CW'(3 % NUM_CLASSES)]) : '0;
    assign total_served  = served_reg;

endmodule

FILE: sv/spq_checker.sv
// Port-level assertions for the strict priority queue core, bound to the top.
module spq_checker
    import spq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [STAT_W-1:0] status,
    input logic [CLS_W-1:0]  served_class,
    input logic [TAG_W-1:0]  served_tag,
    input logic [SERVE_W-1:0] total_served
);

    // A result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result beat dropped or changed while stalled");

    // Never ready for input while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    // A failed result carries no served class or tag
    a_served: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> served_class == '0 && served_tag == '0)
        else $error("served fields set on failed operation");

    // Served total changes only while a result is shown
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(out_valid) |-> $stable(total_served))
        else $error("served total moved outside a call");

endmodule

bind strict_priority_four_class_queue_core spq_checker u_spq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .served_class(served_class), .served_tag(served_tag),
    .total_served(total_served)
);
